>>> hw/rtl/tfht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tfht_pkg;

  // Default number of flow table entries.
  localparam int TABLE_ENTRIES_DEF = 16;

  // Header constants.
  localparam logic [15:0] LINK_HDR_BYTES = 16'd14;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;

  // TCP flag patterns (bit 1 SYN, bit 0 ACK).
  localparam logic [1:0] FLAGS_ACK    = 2'b01;
  localparam logic [1:0] FLAGS_SYN    = 2'b10;
  localparam logic [1:0] FLAGS_SYNACK = 2'b11;

  // Handshake states.
  localparam logic [1:0] HS_NONE   = 2'd0;
  localparam logic [1:0] HS_SYN    = 2'd1;
  localparam logic [1:0] HS_SYNACK = 2'd2;
  localparam logic [1:0] HS_DONE   = 2'd3;

  // Queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  typedef enum logic [2:0] {
    ST_TRACKED   = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_OTHER     = 3'd2,
    ST_PLACED    = 3'd3,
    ST_NOT_TCP   = 3'd4,
    ST_SHORT     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    KIND_SHORT   = 2'd0,
    KIND_NOT_TCP = 2'd1,
    KIND_TCP     = 2'd2
  } kind_t;

  typedef enum logic {
    BK_LOAD = 1'b0,
    BK_EXEC = 1'b1
  } bk_state_t;

  typedef struct packed {
    logic [31:0] a0;
    logic [31:0] a1;
    logic [15:0] p0;
    logic [15:0] p1;
  } flow_key_t;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    kind_t              kind;
    logic signed [16:0] plen;
    flow_key_t          key;
    logic [1:0]         flags;
    logic [31:0]        seq;
    logic [31:0]        ack;
  } cmd_t;

  // Handshake between two parts.
  typedef struct packed {
    logic valid;
    logic ready;
  } link_t;

  // A flow matches in either direction.
  function automatic logic key_match(input flow_key_t t, input flow_key_t f);
    logic fwd;
    logic rev;
    fwd = (t.a0 == f.a0) && (t.a1 == f.a1) && (t.p0 == f.p0) && (t.p1 == f.p1);
    rev = (t.a0 == f.a1) && (t.a1 == f.a0) && (t.p0 == f.p1) && (t.p1 == f.p0);
    return fwd || rev;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tfht_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: parsed header fields of one frame.
interface tfht_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_len;
  logic [7:0]  protocol;
  logic [3:0]  ip_hdr_words;
  logic [15:0] ip_total_len;
  logic [3:0]  tcp_hdr_words;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] sport;
  logic [15:0] dport;
  logic [1:0]  tcp_flags;
  logic [31:0] seq_num;
  logic [31:0] ack_num;

  modport source (
    output valid, frame_len, protocol, ip_hdr_words, ip_total_len, tcp_hdr_words,
           src_addr, dst_addr, sport, dport, tcp_flags, seq_num, ack_num,
    input  ready
  );

  modport sink (
    input  valid, frame_len, protocol, ip_hdr_words, ip_total_len, tcp_hdr_words,
           src_addr, dst_addr, sport, dport, tcp_flags, seq_num, ack_num,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/tfht_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Result channel: one result per request.
interface tfht_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] write_offset;
  logic signed [16:0] payload_len;
  logic [31:0]        stored_total;
  logic               locked;
  logic               table_full_drop;

  modport source (
    output valid, status, write_offset, payload_len, stored_total, locked,
           table_full_drop,
    input  ready
  );

  modport sink (
    input  valid, status, write_offset, payload_len, stored_total, locked,
           table_full_drop,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/tcp_flow_handshake_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

// TCP handshake tracker. Each request carries the parsed header fields of one
// TCP/IPv4 frame and gives exactly one result. Short and non-TCP frames are
// rejected; until a flow completes its three-way handshake the frame's flow
// is tracked in a table of TABLE_ENTRIES entries, and after the first flow
// locks, its payload frames get a reassembly write offset and a running byte
// total. The back part compares the request against all table entries in
// parallel as it leaves the queue, then updates the table and loads the
// result register, and takes no new request before committing the last. A
// request passes the front register, the queue, the lookup registers and the
// output register in turn. The front register and a two-entry queue let new
// requests be accepted while a result waits to be taken. The table needs no
// clearing after reset; only entries below the fill count are compared.
module tcp_flow_handshake_tracker
  import tfht_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
  input  wire logic  clk,
  input  wire logic  rst,
  tfht_req_if.sink   req,
  tfht_rsp_if.source rsp
);

  link_t push_ctl;
  logic  push_ready;
  cmd_t  push_cmd;
  link_t pop_ctl;
  logic  pop_take;
  cmd_t  pop_cmd;

  tfht_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push_ctl   (push_ctl),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  tfht_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_ctl.valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_ctl    (pop_ctl),
    .pop_take   (pop_take),
    .pop_cmd    (pop_cmd)
  );

  tfht_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_ctl  (pop_ctl),
    .pop_take (pop_take),
    .pop_cmd  (pop_cmd),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire

>>> hw/rtl/tfht_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tfht_front
  import tfht_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  tfht_req_if.sink   req,
  output link_t      push_ctl,
  input  wire logic  push_ready,
  output cmd_t       push_cmd
);

  logic fr_valid;
  cmd_t fr_cmd;
  cmd_t cmd_next;
  logic req_fire;

  assign req.ready = !fr_valid || push_ready;
  assign req_fire  = req.valid && req.ready;

  // Classify the frame and work out the TCP payload length.
  always_comb begin
    cmd_next.key   = '{a0: req.src_addr, a1: req.dst_addr,
                       p0: req.sport, p1: req.dport};
    cmd_next.flags = req.tcp_flags;
    cmd_next.seq   = req.seq_num;
    cmd_next.ack   = req.ack_num;
    cmd_next.plen  = '0;
    if (req.frame_len <= LINK_HDR_BYTES) begin
      cmd_next.kind = KIND_SHORT;
    end else if (req.protocol != PROTO_TCP) begin
      cmd_next.kind = KIND_NOT_TCP;
    end else begin
      cmd_next.kind = KIND_TCP;
      cmd_next.plen = $signed({1'b0, req.ip_total_len})
                    - $signed({11'd0, req.ip_hdr_words, 2'b00})
                    - $signed({11'd0, req.tcp_hdr_words, 2'b00});
    end
  end

  // One holding register in front of the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (req_fire) begin
      fr_valid <= 1'b1;
    end else if (push_ready) begin
      fr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      fr_cmd <= cmd_next;
    end
  end

  assign push_ctl.valid = fr_valid;
  assign push_ctl.ready = req.ready;
  assign push_cmd       = fr_cmd;

endmodule

`default_nettype wire

>>> hw/rtl/tfht_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tfht_queue
  import tfht_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  cmd_t      push_cmd,
  output link_t     pop_ctl,
  input  wire logic pop_take,
  output cmd_t      pop_cmd
);

  cmd_t                   slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   push_fire;
  logic                   pop_fire;

  assign push_ready    = count != QUEUE_CNT_W'(QUEUE_DEPTH);
  assign pop_ctl.valid = count != '0;
  assign pop_ctl.ready = pop_take;
  assign push_fire     = push_valid && push_ready;
  assign pop_fire      = pop_take && pop_ctl.valid;
  assign pop_cmd       = slots[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count <= count + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tfht_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tfht_back
  import tfht_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  link_t      pop_ctl,
  output logic       pop_take,
  input  cmd_t       pop_cmd,
  tfht_rsp_if.source rsp
);

  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // Flow table and tracker state.
  flow_key_t   tbl_key   [TABLE_ENTRIES];
  logic [1:0]  tbl_state [TABLE_ENTRIES];
  logic [CW-1:0] flow_count;
  logic        locked_flag;
  flow_key_t   locked_key;
  logic [31:0] base_seq;
  logic [31:0] base_ack;
  logic [31:0] byte_total;

  // Request under way.
  bk_state_t   state;
  bk_state_t   state_next;
  cmd_t        cur;
  logic        hit_any;
  logic [IW-1:0] hit_idx;
  logic [1:0]  hit_state;
  logic        locked_hit;

  // Lookup results for the queue head.
  logic [TABLE_ENTRIES-1:0] hit_vec;
  logic          hit_any_next;
  logic [IW-1:0] hit_idx_next;

  // Commit results.
  logic          commit;
  logic          load;
  status_t       st_next;
  logic [31:0]   offset_next;
  logic          drop_next;
  logic [1:0]    hs_next;
  logic          tbl_update;
  logic          tbl_insert;
  logic          lock_now;
  logic          base_load;
  logic [31:0]   byte_total_next;
  logic [31:0]   plen_u;
  logic          out_valid;

  assign commit = (state == BK_EXEC) && (!out_valid || rsp.ready);
  assign load   = (state == BK_LOAD) && pop_ctl.valid;
  assign plen_u = {{15{cur.plen[16]}}, cur.plen};

  // Compare the queue head against every valid table entry.
  always_comb begin
    hit_idx_next = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_vec[i] = (CW'(i) < flow_count) && key_match(tbl_key[i], pop_cmd.key);
    end
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx_next = IW'(i);
      end
    end
    hit_any_next = |hit_vec;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      BK_LOAD: begin
        if (pop_ctl.valid) begin
          state_next = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (commit) begin
          state_next = BK_LOAD;
        end
      end
      default: state_next = BK_LOAD;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    pop_take = 1'b0;
    case (state)
      BK_LOAD: pop_take = 1'b1;
      BK_EXEC: pop_take = 1'b0;
      default: pop_take = 1'b0;
    endcase
  end

  // Handshake step of a matched entry.
  always_comb begin
    if (hit_state == HS_NONE && cur.flags == FLAGS_SYN) begin
      hs_next = HS_SYN;
    end else if (hit_state == HS_SYN && cur.flags == FLAGS_SYNACK) begin
      hs_next = HS_SYNACK;
    end else if (hit_state == HS_SYNACK && cur.flags == FLAGS_ACK) begin
      hs_next = HS_DONE;
    end else begin
      hs_next = hit_state;
    end
  end

  // Decide the result and the state updates of the current request.
  always_comb begin
    st_next         = ST_TRACKED;
    offset_next     = '0;
    drop_next       = 1'b0;
    tbl_update      = 1'b0;
    tbl_insert      = 1'b0;
    lock_now        = 1'b0;
    base_load       = 1'b0;
    byte_total_next = byte_total;
    case (cur.kind)
      KIND_SHORT:   st_next = ST_SHORT;
      KIND_NOT_TCP: st_next = ST_NOT_TCP;
      KIND_TCP: begin
        if (!locked_flag) begin
          st_next = ST_TRACKED;
          if (hit_any) begin
            tbl_update = 1'b1;
            lock_now   = hs_next == HS_DONE;
          end else if (flow_count < CW'(TABLE_ENTRIES)) begin
            tbl_insert = 1'b1;
          end else begin
            drop_next = 1'b1;
          end
        end else if (cur.plen[16] || cur.plen == '0) begin
          st_next = ST_EMPTY;
        end else if (!locked_hit) begin
          st_next = ST_OTHER;
        end else begin
          st_next = ST_PLACED;
          if (byte_total == '0) begin
            base_load       = 1'b1;
            byte_total_next = plen_u;
          end else begin
            offset_next     = (cur.seq - base_seq) + (cur.ack - base_ack);
            byte_total_next = byte_total + plen_u;
          end
        end
      end
      default: st_next = ST_SHORT;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_LOAD;
      flow_count  <= '0;
      locked_flag <= 1'b0;
      byte_total  <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        out_valid  <= 1'b1;
        byte_total <= byte_total_next;
        if (tbl_insert) begin
          flow_count <= flow_count + 1'b1;
        end
        if (lock_now) begin
          locked_flag <= 1'b1;
        end
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Lookup registers, loaded as the request leaves the queue.
  always_ff @(posedge clk) begin
    if (load) begin
      cur        <= pop_cmd;
      hit_any    <= hit_any_next;
      hit_idx    <= hit_idx_next;
      hit_state  <= tbl_state[hit_idx_next];
      locked_hit <= key_match(locked_key, pop_cmd.key);
    end
  end

  // Table, lock and base registers.
  always_ff @(posedge clk) begin
    if (commit) begin
      if (tbl_update) begin
        tbl_state[hit_idx] <= hs_next;
      end
      if (tbl_insert) begin
        tbl_key[flow_count[IW-1:0]]   <= cur.key;
        tbl_state[flow_count[IW-1:0]] <= (cur.flags == FLAGS_SYN) ? HS_SYN : HS_NONE;
      end
      if (lock_now) begin
        locked_key <= cur.key;
      end
      if (base_load) begin
        base_seq <= cur.seq;
        base_ack <= cur.ack;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (commit) begin
      rsp.status          <= st_next;
      rsp.write_offset    <= $signed(offset_next);
      rsp.payload_len     <= cur.plen;
      rsp.stored_total    <= byte_total_next;
      rsp.locked          <= locked_flag || lock_now;
      rsp.table_full_drop <= drop_next;
    end
  end

  assign rsp.valid = out_valid;

endmodule

`default_nettype wire
